// File: hdl/ssva_pkg.sv
package ssva_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int ID_BITS_DEF  = 24;

  // field widths fixed by the stream format
  localparam int VOXEL_ID_W  = 24;
  localparam int VALUE_W     = 32;
  localparam int INDEX_W     = 6;
  localparam int COUNT_OUT_W = 7;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7fff_ffff;
  localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_MERGED   = 2'd1,
    ST_DROPPED  = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  // what a travelling item is doing as it passes a cell
  typedef enum logic [1:0] {
    M_SEARCH = 2'd0,
    M_SHIFT  = 2'd1,
    M_READ   = 2'd2,
    M_DONE   = 2'd3
  } mode_t;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_READ   = 1'b1
  } action_t;

  typedef struct packed {
    logic                valid;
    action_t             action;
    mode_t               mode;
    status_t             status;
    logic                saturated;
    logic [INDEX_W-1:0]  position;
    logic [INDEX_W-1:0]  read_index;
  } ctl_t;

endpackage

// File: hdl/ssva_cell.sv
module ssva_cell #(
  parameter int CAPACITY = ssva_pkg::CAPACITY_DEF,
  parameter int ID_BITS  = ssva_pkg::ID_BITS_DEF,
  parameter int IDX      = 0,
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic [CW-1:0]                   count,
  input  ssva_pkg::ctl_t                  ctl_in,
  input  logic [ID_BITS-1:0]              d_id_in,
  input  logic [ssva_pkg::VALUE_W-1:0]    d_val_in,
  input  logic [ID_BITS-1:0]              res_id_in,
  input  logic [ssva_pkg::VALUE_W-1:0]    res_val_in,
  output ssva_pkg::ctl_t                  ctl_out,
  output logic [ID_BITS-1:0]              d_id_out,
  output logic [ssva_pkg::VALUE_W-1:0]    d_val_out,
  output logic [ID_BITS-1:0]              res_id_out,
  output logic [ssva_pkg::VALUE_W-1:0]    res_val_out
);

  localparam logic [CW-1:0] IDX_C = CW'(IDX);
  localparam logic [CW-1:0] FULL_C = CW'(CAPACITY);
  localparam logic [ssva_pkg::INDEX_W-1:0] POS_C = ssva_pkg::INDEX_W'(IDX);

  logic [ID_BITS-1:0]           entry_id;
  logic [ssva_pkg::VALUE_W-1:0] entry_val;

  ssva_pkg::ctl_t               ctl_next;
  logic [ID_BITS-1:0]           d_id_next;
  logic [ssva_pkg::VALUE_W-1:0] d_val_next;
  logic [ID_BITS-1:0]           res_id_next;
  logic [ssva_pkg::VALUE_W-1:0] res_val_next;
  logic                         wr;
  logic [ID_BITS-1:0]           wr_id;
  logic [ssva_pkg::VALUE_W-1:0] wr_val;

  logic                         occupied;
  logic                         full;
  logic signed [ssva_pkg::VALUE_W:0] sum;
  logic                         ovf;
  logic [ssva_pkg::VALUE_W-1:0] sum_sat;

  assign occupied = IDX_C < count;
  assign full     = count == FULL_C;
  assign sum      = $signed({entry_val[ssva_pkg::VALUE_W-1], entry_val})
                  + $signed({d_val_in[ssva_pkg::VALUE_W-1], d_val_in});
  assign ovf      = sum[ssva_pkg::VALUE_W] != sum[ssva_pkg::VALUE_W-1];
  assign sum_sat  = !ovf ? sum[ssva_pkg::VALUE_W-1:0]
                  : (sum[ssva_pkg::VALUE_W] ? ssva_pkg::VALUE_MIN : ssva_pkg::VALUE_MAX);

  always_comb begin
    ctl_next     = ctl_in;
    d_id_next    = d_id_in;
    d_val_next   = d_val_in;
    res_id_next  = res_id_in;
    res_val_next = res_val_in;
    wr           = 1'b0;
    wr_id        = d_id_in;
    wr_val       = d_val_in;
    if (ctl_in.valid) begin
      case (ctl_in.mode)
        ssva_pkg::M_SEARCH: begin
          if (occupied) begin
            if (entry_id == d_id_in) begin
              wr                 = 1'b1;
              wr_id              = entry_id;
              wr_val             = sum_sat;
              ctl_next.mode      = ssva_pkg::M_DONE;
              ctl_next.status    = ssva_pkg::ST_MERGED;
              ctl_next.position  = POS_C;
              ctl_next.saturated = ovf;
              res_id_next        = entry_id;
              res_val_next       = sum_sat;
            end else if (entry_id > d_id_in) begin
              if (full) begin
                ctl_next.mode     = ssva_pkg::M_DONE;
                ctl_next.status   = ssva_pkg::ST_DROPPED;
                ctl_next.position = '0;
                res_id_next       = d_id_in;
                res_val_next      = '0;
              end else begin
                // take the new entry, push the old one up the row
                wr                = 1'b1;
                ctl_next.mode     = ssva_pkg::M_SHIFT;
                ctl_next.status   = ssva_pkg::ST_INSERTED;
                ctl_next.position = POS_C;
                res_id_next       = d_id_in;
                res_val_next      = d_val_in;
                d_id_next         = entry_id;
                d_val_next        = entry_val;
              end
            end
          end else if (IDX_C == count) begin
            // first free slot, append
            wr                = 1'b1;
            ctl_next.mode     = ssva_pkg::M_DONE;
            ctl_next.status   = ssva_pkg::ST_INSERTED;
            ctl_next.position = POS_C;
            res_id_next       = d_id_in;
            res_val_next      = d_val_in;
          end
        end
        ssva_pkg::M_SHIFT: begin
          if (IDX_C <= count) begin
            wr         = 1'b1;
            d_id_next  = entry_id;
            d_val_next = entry_val;
          end
        end
        ssva_pkg::M_READ: begin
          if (occupied && ({26'b0, ctl_in.read_index} == 32'(IDX))) begin
            ctl_next.mode     = ssva_pkg::M_DONE;
            ctl_next.status   = ssva_pkg::ST_INSERTED;
            ctl_next.position = POS_C;
            res_id_next       = entry_id;
            res_val_next      = entry_val;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_next.valid;
    end
    if (en) begin
      ctl_out.action     <= ctl_next.action;
      ctl_out.mode       <= ctl_next.mode;
      ctl_out.status     <= ctl_next.status;
      ctl_out.saturated  <= ctl_next.saturated;
      ctl_out.position   <= ctl_next.position;
      ctl_out.read_index <= ctl_next.read_index;
      d_id_out           <= d_id_next;
      d_val_out          <= d_val_next;
      res_id_out         <= res_id_next;
      res_val_out        <= res_val_next;
    end
    if (en && wr) begin
      entry_id  <= wr_id;
      entry_val <= wr_val;
    end
  end

endmodule

// File: hdl/sorted_sparse_voxel_accumulator.sv
// Sorted sparse voxel accumulator. Holds up to CAPACITY (id, value) entries in a row
// of cells kept in ascending id order. An insert item (tuser 0) either adds its Q15.16
// value to the entry with the same id, saturating at the signed 32-bit limits, or
// slides into its sorted place while the later entries move up one cell; a new id on a
// full table is dropped with status 2. A read item (tuser 1) returns the entry at a
// sorted index, or status 3 if that index holds nothing. Each item travels the row of
// cells once, one cell a clock while the row is not stalled, and its result then moves
// into the output register. The next item is not taken before the previous one has
// left the row, so the row of cells never holds more than one item at a time.
// The result register lets the row finish an item while the previous result waits;
// the row stalls only if a second result arrives before the first is taken. No
// clearing pass is needed after reset.
module sorted_sparse_voxel_accumulator #(
  parameter int CAPACITY = ssva_pkg::CAPACITY_DEF,
  parameter int ID_BITS  = ssva_pkg::ID_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // voxel_id[23:0], voxel_value[55:24], read_index[61:56], zero fill
  input  logic [63:0] s_tdata,
  // action
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // position[5:0], entry_count[12:6], out_id[36:13], out_value[68:37],
  // saturated[69], zero fill
  output logic [71:0] m_tdata,
  // status
  output logic [1:0]  m_tuser
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int VW = ssva_pkg::VALUE_W;
  localparam int KB = (ID_BITS < ssva_pkg::VOXEL_ID_W) ? ID_BITS : ssva_pkg::VOXEL_ID_W;

  // links between the cells, link 0 is fed straight from the input
  ssva_pkg::ctl_t     chain_ctl     [CAPACITY+1];
  logic [ID_BITS-1:0] chain_d_id    [CAPACITY+1];
  logic [VW-1:0]      chain_d_val   [CAPACITY+1];
  logic [ID_BITS-1:0] chain_res_id  [CAPACITY+1];
  logic [VW-1:0]      chain_res_val [CAPACITY+1];

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          busy;
  logic          en;
  logic          accept;
  logic          finish;

  ssva_pkg::ctl_t     last;
  ssva_pkg::status_t  fin_status;
  logic [5:0]         fin_pos;
  logic [ID_BITS-1:0] fin_id;
  logic [VW-1:0]      fin_val;
  logic               fin_sat;

  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;

  // hold the whole row if a result reaches the end while the last one is unread
  assign last   = chain_ctl[CAPACITY];
  assign en     = !(last.valid && m_tvalid && !m_tready);
  assign finish = last.valid && en;

  // new item enters the first cell
  always_comb begin
    chain_ctl[0].valid      = accept;
    chain_ctl[0].action     = ssva_pkg::action_t'(s_tuser[0]);
    chain_ctl[0].mode       = s_tuser[0] ? ssva_pkg::M_READ : ssva_pkg::M_SEARCH;
    chain_ctl[0].status     = ssva_pkg::ST_INSERTED;
    chain_ctl[0].saturated  = 1'b0;
    chain_ctl[0].position   = '0;
    chain_ctl[0].read_index = s_tdata[61:56];
    chain_d_id[0]           = ID_BITS'(s_tdata[KB-1:0]);
    chain_d_val[0]          = s_tdata[55:24];
    chain_res_id[0]         = '0;
    chain_res_val[0]        = '0;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_row
    ssva_cell #(
      .CAPACITY (CAPACITY),
      .ID_BITS  (ID_BITS),
      .IDX      (g)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .en          (en),
      .count       (count),
      .ctl_in      (chain_ctl[g]),
      .d_id_in     (chain_d_id[g]),
      .d_val_in    (chain_d_val[g]),
      .res_id_in   (chain_res_id[g]),
      .res_val_in  (chain_res_val[g]),
      .ctl_out     (chain_ctl[g+1]),
      .d_id_out    (chain_d_id[g+1]),
      .d_val_out   (chain_d_val[g+1]),
      .res_id_out  (chain_res_id[g+1]),
      .res_val_out (chain_res_val[g+1])
    );
  end

  // resolve what the item still carries as it leaves the last cell
  always_comb begin
    fin_status = last.status;
    fin_pos    = last.position;
    fin_id     = chain_res_id[CAPACITY];
    fin_val    = chain_res_val[CAPACITY];
    fin_sat    = last.saturated;
    count_next = count;
    case (last.mode)
      ssva_pkg::M_READ: begin
        // no cell matched the index
        fin_status = ssva_pkg::ST_RANGE;
        fin_pos    = last.read_index;
        fin_id     = '0;
        fin_val    = '0;
        fin_sat    = 1'b0;
      end
      ssva_pkg::M_SEARCH: begin
        // passed a full row without a match or a larger id
        fin_status = ssva_pkg::ST_DROPPED;
        fin_pos    = '0;
        fin_id     = chain_d_id[CAPACITY];
        fin_val    = '0;
        fin_sat    = 1'b0;
      end
      default: begin
        if (last.action == ssva_pkg::ACT_INSERT && last.status == ssva_pkg::ST_INSERTED) begin
          count_next = count + CW'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (finish) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_tuser        <= fin_status;
      m_tdata[5:0]   <= fin_pos;
      m_tdata[12:6]  <= ssva_pkg::COUNT_OUT_W'(count_next);
      m_tdata[36:13] <= ssva_pkg::VOXEL_ID_W'(fin_id);
      m_tdata[68:37] <= fin_val;
      m_tdata[69]    <= fin_sat;
      m_tdata[71:70] <= 2'b00;
    end
  end

endmodule

// File: bench/sorted_sparse_voxel_accumulator_test.sv
module sorted_sparse_voxel_accumulator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ssva_pkg::*;

  localparam int CAP            = CAPACITY_DEF;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int PHASES         = 8;
  localparam int HOLD_CYCLES    = 600;
  // one item walks the whole row of cells before its result shows up
  localparam int DRAIN_CYCLES   = CAP + 16;
  localparam int WATCHDOG_LIMIT = 8000;

  // sender gap and receiver stall, in percent, for each random phase
  localparam int SEND_GAP [PHASES] = '{0, 60, 0, 22, 0, 60, 0, 22};
  localparam int RX_STALL [PHASES] = '{0, 0, 60, 22, 0, 0, 60, 22};

  typedef struct packed {
    status_t                  status;
    logic [INDEX_W-1:0]       position;
    logic [COUNT_OUT_W-1:0]   entry_count;
    logic [VOXEL_ID_W-1:0]    out_id;
    logic [VALUE_W-1:0]       out_value;
    logic                     saturated;
  } voxel_result_t;

  typedef struct packed {
    action_t                  act;
    logic [VOXEL_ID_W-1:0]    id;
    logic [VALUE_W-1:0]       value;
    logic [INDEX_W-1:0]       idx;
    logic                     typed;
    voxel_result_t            want;
  } stim_row_t;

  // directed opening: empty-table reads, id and value extremes, ordered
  // placement at the front, back and middle, merges that clip high and low,
  // merges that cancel, and a read sweep across the end of the table
  localparam int NDIR = 22;
  localparam stim_row_t DIR_ROWS [NDIR] = '{
    '{ACT_READ,   24'h000000, 32'h0000_0000, 6'd0,  1'b1,
      '{ST_RANGE,    6'd0,  7'd0, 24'h000000, 32'h0000_0000, 1'b0}},
    '{ACT_READ,   24'h000000, 32'h0000_0000, 6'd63, 1'b1,
      '{ST_RANGE,    6'd63, 7'd0, 24'h000000, 32'h0000_0000, 1'b0}},
    '{ACT_INSERT, 24'h000100, 32'h0001_0000, 6'd0,  1'b1,
      '{ST_INSERTED, 6'd0,  7'd1, 24'h000100, 32'h0001_0000, 1'b0}},
    '{ACT_INSERT, 24'hffffff, 32'h7fff_ffff, 6'd0,  1'b1,
      '{ST_INSERTED, 6'd1,  7'd2, 24'hffffff, 32'h7fff_ffff, 1'b0}},
    '{ACT_INSERT, 24'h000000, 32'h8000_0000, 6'd0,  1'b1,
      '{ST_INSERTED, 6'd0,  7'd3, 24'h000000, 32'h8000_0000, 1'b0}},
    '{ACT_INSERT, 24'h000080, 32'hffff_ffff, 6'd0,  1'b0, '0},
    '{ACT_INSERT, 24'hffffff, 32'h0000_0001, 6'd0,  1'b0, '0},
    '{ACT_INSERT, 24'h000000, 32'hffff_ffff, 6'd0,  1'b0, '0},
    '{ACT_INSERT, 24'h000100, 32'h0000_8000, 6'd0,  1'b0, '0},
    '{ACT_INSERT, 24'h000080, 32'h0000_0001, 6'd0,  1'b0, '0},
    '{ACT_INSERT, 24'h800000, 32'h1234_5678, 6'd0,  1'b0, '0},
    '{ACT_INSERT, 24'hffffff, 32'h8000_0000, 6'd0,  1'b0, '0},
    '{ACT_INSERT, 24'h000000, 32'h7fff_ffff, 6'd0,  1'b0, '0},
    '{ACT_INSERT, 24'h7fffff, 32'h00aa_5500, 6'd0,  1'b0, '0},
    '{ACT_READ,   24'h000000, 32'h0000_0000, 6'd0,  1'b0, '0},
    '{ACT_READ,   24'h000000, 32'h0000_0000, 6'd1,  1'b0, '0},
    '{ACT_READ,   24'h000000, 32'h0000_0000, 6'd2,  1'b0, '0},
    '{ACT_READ,   24'h000000, 32'h0000_0000, 6'd3,  1'b0, '0},
    '{ACT_READ,   24'h000000, 32'h0000_0000, 6'd4,  1'b0, '0},
    '{ACT_READ,   24'h000000, 32'h0000_0000, 6'd5,  1'b0, '0},
    '{ACT_READ,   24'h000000, 32'h0000_0000, 6'd6,  1'b0, '0},
    '{ACT_READ,   24'h000000, 32'h0000_0000, 6'd63, 1'b1,
      '{ST_RANGE,    6'd63, 7'd6, 24'h000000, 32'h0000_0000, 1'b0}}
  };

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;
  logic [0:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic [1:0]  m_tuser;

  sorted_sparse_voxel_accumulator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the sorted table, kept in step with accepted items
  logic [VOXEL_ID_W-1:0] tab_id  [CAP];
  logic [VALUE_W-1:0]    tab_val [CAP];
  int                    tab_count = 0;

  // results still owed by the block, oldest first
  voxel_result_t pending_results [$];
  voxel_result_t head_result;

  // idling knobs: the sender's is read in the stimulus process only, the
  // receiver's and the hold-off request are handed over by nonblocking writes
  int send_gap_pct = 0;
  int rx_stall_pct = 0;
  int hold_asks    = 0;
  int hold_seen    = 0;

  int mismatches = 0;
  int results_checked = 0;
  int quiet_cycles = 0;
  int n_items = 0, n_reads = 0, n_new = 0, n_merged = 0;
  int n_clipped = 0, n_dropped = 0, n_range = 0;

  // works out what one accepted item does to the table and what comes back
  function automatic voxel_result_t accumulate_voxel(action_t act,
                                                     logic [VOXEL_ID_W-1:0] id,
                                                     logic [VALUE_W-1:0] value,
                                                     logic [INDEX_W-1:0] idx);
    voxel_result_t r;
    int            lo;
    int            i;
    longint        sum;
    r = '0;
    if (act == ACT_READ) begin
      r.position    = idx;
      r.entry_count = COUNT_OUT_W'(tab_count);
      if (int'(idx) >= tab_count) begin
        r.status = ST_RANGE;
      end else begin
        r.status    = ST_INSERTED;
        r.out_id    = tab_id[idx];
        r.out_value = tab_val[idx];
      end
      return r;
    end
    // lower bound: first slot whose id is not below the new one
    lo = 0;
    while (lo < tab_count && tab_id[lo] < id) lo++;
    if (lo < tab_count && tab_id[lo] == id) begin
      sum = longint'($signed(tab_val[lo])) + longint'($signed(value));
      if (sum > longint'($signed(VALUE_MAX))) begin
        tab_val[lo] = VALUE_MAX;
        r.saturated = 1'b1;
      end else if (sum < longint'($signed(VALUE_MIN))) begin
        tab_val[lo] = VALUE_MIN;
        r.saturated = 1'b1;
      end else begin
        tab_val[lo] = VALUE_W'(sum);
      end
      r.status      = ST_MERGED;
      r.position    = INDEX_W'(lo);
      r.entry_count = COUNT_OUT_W'(tab_count);
      r.out_id      = id;
      r.out_value   = tab_val[lo];
      return r;
    end
    if (tab_count >= CAP) begin
      // table full and the id is new: nothing changes
      r.status      = ST_DROPPED;
      r.entry_count = COUNT_OUT_W'(tab_count);
      r.out_id      = id;
      return r;
    end
    for (i = tab_count; i > lo; i--) begin
      tab_id[i]  = tab_id[i-1];
      tab_val[i] = tab_val[i-1];
    end
    tab_id[lo]  = id;
    tab_val[lo] = value;
    tab_count++;
    r.status      = ST_INSERTED;
    r.position    = INDEX_W'(lo);
    r.entry_count = COUNT_OUT_W'(tab_count);
    r.out_id      = id;
    r.out_value   = value;
    return r;
  endfunction

  // offers one item, waits for the handshake, then books its result;
  // a typed row supplies its own expectation, the shadow table still advances
  task automatic offer_item(action_t act, logic [VOXEL_ID_W-1:0] id,
                            logic [VALUE_W-1:0] value, logic [INDEX_W-1:0] idx,
                            logic typed, voxel_result_t want);
    voxel_result_t predicted;
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {2'b00, idx, value, id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = accumulate_voxel(act, id, value, idx);
    pending_results.push_back(typed ? want : predicted);
    n_items++;
    if (act == ACT_READ) n_reads++;
    case (predicted.status)
      ST_INSERTED: if (act == ACT_INSERT) n_new++;
      ST_MERGED:   n_merged++;
      ST_DROPPED:  n_dropped++;
      ST_RANGE:    n_range++;
      default:     ;
    endcase
    if (predicted.saturated) n_clipped++;
  endtask

  // random item: mostly merges onto stored ids, some reads, a trickle of new
  // ids so that the table fills slowly and then starts dropping
  task automatic offer_random_item();
    action_t               act;
    logic [VOXEL_ID_W-1:0] id;
    logic [VALUE_W-1:0]    value;
    logic [INDEX_W-1:0]    idx;
    int                    pick;
    act = ACT_INSERT;
    id  = VOXEL_ID_W'($urandom);
    idx = INDEX_W'($urandom);
    case ($urandom_range(3))
      0: value = $urandom;
      // small deposits of either sign
      1: value = VALUE_W'($urandom_range(32'h000f_ffff)) - 32'h0008_0000;
      2: begin
        case ($urandom_range(3))
          0:       value = VALUE_MAX;
          1:       value = VALUE_MIN;
          2:       value = '0;
          default: value = '1;
        endcase
      end
      default: value = VALUE_W'($signed($urandom) >>> $urandom_range(24));
    endcase
    pick = $urandom_range(99);
    if (pick < 25) begin
      act = ACT_READ;
      // mostly inside the table, now and then anywhere
      if (tab_count > 0 && $urandom_range(3) != 0)
        idx = INDEX_W'($urandom_range(tab_count - 1));
    end else if (pick < 32 || tab_count == 0) begin
      // new id: anywhere, or right beside a stored one
      if (tab_count > 0 && $urandom_range(2) == 0)
        id = tab_id[$urandom_range(tab_count - 1)] +
             ($urandom_range(1) ? 24'h000001 : 24'hffffff);
    end else begin
      id = tab_id[$urandom_range(tab_count - 1)];
    end
    offer_item(act, id, value, idx, 1'b0, '0);
  endtask

  // receiver: random stalls per phase, plus a long hold-off on request
  initial begin : receiver
    int k;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        m_tready <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      end
      m_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, status %0d data %h",
                 $time, m_tuser, m_tdata);
        mismatches++;
      end else begin
        head_result = pending_results.pop_front();
        if (m_tuser != head_result.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, head_result.status, m_tuser);
          mismatches++;
        end
        if (m_tdata[5:0] != head_result.position) begin
          $display("%0t: position expected %0d actual %0d",
                   $time, head_result.position, m_tdata[5:0]);
          mismatches++;
        end
        if (m_tdata[12:6] != head_result.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d",
                   $time, head_result.entry_count, m_tdata[12:6]);
          mismatches++;
        end
        if (m_tdata[36:13] != head_result.out_id) begin
          $display("%0t: out_id expected %h actual %h",
                   $time, head_result.out_id, m_tdata[36:13]);
          mismatches++;
        end
        if (m_tdata[68:37] != head_result.out_value) begin
          $display("%0t: out_value expected %h actual %h",
                   $time, head_result.out_value, m_tdata[68:37]);
          mismatches++;
        end
        if (m_tdata[69] != head_result.saturated) begin
          $display("%0t: saturated expected %0d actual %0d",
                   $time, head_result.saturated, m_tdata[69]);
          mismatches++;
        end
      end
    end
    // nothing moving on either side for too long means the block is stuck
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending_results.size());
      $display("sorted_sparse_voxel_accumulator test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int ph;
    int k;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < NDIR; k++)
      offer_item(DIR_ROWS[k].act, DIR_ROWS[k].id, DIR_ROWS[k].value,
                 DIR_ROWS[k].idx, DIR_ROWS[k].typed, DIR_ROWS[k].want);

    for (ph = 0; ph < PHASES; ph++) begin
      // sender pauses until every owed result is back
      s_tvalid <= 1'b0;
      do @(posedge clk); while (pending_results.size() != 0);
      send_gap_pct = SEND_GAP[ph];
      rx_stall_pct <= RX_STALL[ph];
      // long receiver hold-off while the sender keeps pushing, so the row backs up
      if (ph % 4 == 0) hold_asks <= hold_asks + 1;
      for (k = 0; k < RANDOM_ITEMS / PHASES; k++) offer_random_item();
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    // give a stray extra result time to surface
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d items (%0d reads), %0d results checked, table ended with %0d entries",
             n_items, n_reads, results_checked, tab_count);
    $display("new %0d, merged %0d (clipped %0d), dropped on full %0d, reads out of range %0d",
             n_new, n_merged, n_clipped, n_dropped, n_range);
    if (mismatches == 0) begin
      $display("sorted_sparse_voxel_accumulator test passed");
    end else begin
      $display("sorted_sparse_voxel_accumulator test failed");
    end
    $finish;
  end

endmodule

// File: sorted_sparse_voxel_accumulator.f
hdl/ssva_pkg.sv
hdl/ssva_cell.sv
hdl/sorted_sparse_voxel_accumulator.sv
bench/sorted_sparse_voxel_accumulator_test.sv
